// ===== src/four_level_page_walk_top_macros.svh =====
// Assertion macros for the page walk RTL files (included by flpw_walker.sv).
`ifndef FOUR_LEVEL_PAGE_WALK_TOP_MACROS_SVH
`define FOUR_LEVEL_PAGE_WALK_TOP_MACROS_SVH

`ifndef SYNTH
`define FLPW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FLPW_ASSERT_IMPL(lbl, pre, post, msg) \
    `FLPW_ASSERT(lbl, (pre) |-> (post), msg)
`define FLPW_ASSERT_NEXT(lbl, pre, post, msg) \
    `FLPW_ASSERT(lbl, (pre) |=> (post), msg)
`else
`define FLPW_ASSERT(lbl, prop, msg)
`define FLPW_ASSERT_IMPL(lbl, pre, post, msg)
`define FLPW_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== src/flpw_pkg.sv =====
// Types, constants and helpers shared by the page walk modules.
`default_nettype none

package flpw_pkg;

    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = 9;
    localparam int FRAME_W           = 40;
    localparam int VA_W              = 48;

    localparam logic ACT_WRITE     = 1'b0;
    localparam logic ACT_TRANSLATE = 1'b1;

    // Bit positions in an x86-64 entry word.
    localparam int BIT_P   = 0;
    localparam int BIT_RW  = 1;
    localparam int BIT_US  = 2;
    localparam int BIT_PCD = 4;
    localparam int FRAME_LSB = 12;

    typedef struct packed {
        logic                action;
        logic [VA_W-1:0]     virt_addr;
        logic [5:0]          entry_frame;
        logic [IDX_W-1:0]    entry_index;
        logic [63:0]         entry_word;
    } req_item_t;

    typedef struct packed {
        logic                mapped;
        logic [FRAME_W-1:0]  phys_frame;
        logic                writable;
        logic                user_access;
        logic                cache_disable;
    } rsp_item_t;

    // One stored table entry: the kept bits of the entry word.
    typedef struct packed {
        logic [FRAME_W-1:0]  frame;
        logic                pcd;
        logic                user;
        logic                rw;
        logic                present;
    } entry_t;

    function automatic entry_t entry_from_word(input logic [63:0] word);
        entry_t e;
        e.frame   = word[FRAME_LSB +: FRAME_W];
        e.pcd     = word[BIT_PCD];
        e.user    = word[BIT_US];
        e.rw      = word[BIT_RW];
        e.present = word[BIT_P];
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== src/flpw_table_ram.sv =====
// Table store: single write port, single read port, registered read data.
`default_nettype none

module flpw_table_ram #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire flpw_pkg::entry_t  wdata,
    input  wire logic [AW-1:0]     raddr,
    output flpw_pkg::entry_t       rdata
);
    import flpw_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/flpw_walker.sv =====
// Walk sequencer: clearing pass, entry writes, four-level walk, result register.
`default_nettype none

`include "four_level_page_walk_top_macros.svh"

module flpw_walker #(
    parameter int FRAMES = 64,
    parameter int AW     = 15
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [5:0]          root_frame,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire flpw_pkg::req_item_t req_item,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output flpw_pkg::rsp_item_t      rsp_item,
    output logic                     mem_we,
    output logic [AW-1:0]            mem_waddr,
    output flpw_pkg::entry_t         mem_wdata,
    output logic [AW-1:0]            mem_raddr,
    input  wire flpw_pkg::entry_t    mem_rdata
);
    import flpw_pkg::*;

    localparam int DEPTH = FRAMES * ENTRIES_PER_TABLE;
    localparam int FW    = AW - IDX_W;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_WALK, S_DONE} state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [1:0]        level_reg, level_next;
    logic [26:0]       va_lo_reg, va_lo_next;
    rsp_item_t         res_reg, res_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_item_t         rsp_item_reg, rsp_item_next;

    logic              req_accept;
    logic              rsp_free;
    logic              fin;
    rsp_item_t         fin_item;

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_item   = rsp_item_reg;

    always_comb
    begin
        logic [8:0] idx_next;
        logic       root_ok;
        logic       wr_ok;

        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        level_next     = level_reg;
        va_lo_next     = va_lo_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_item_next  = rsp_item_reg;
        mem_we         = 1'b0;
        mem_waddr      = clr_addr_reg;
        mem_wdata      = '0;
        mem_raddr      = '0;
        fin            = 1'b0;
        fin_item       = '0;

        root_ok = ({34'd0, root_frame} < FRAME_W'(FRAMES));
        wr_ok   = ({34'd0, req_item.entry_frame} < FRAME_W'(FRAMES));

        case (level_reg)
            2'd0:    idx_next = va_lo_reg[26:18];
            2'd1:    idx_next = va_lo_reg[17:9];
            2'd2:    idx_next = va_lo_reg[8:0];
            default: idx_next = '0;
        endcase

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_accept)
                begin
                    if (req_item.action == ACT_WRITE)
                    begin
                        // Writes to a frame outside the store are dropped.
                        mem_we    = wr_ok;
                        mem_waddr = {FW'({34'd0, req_item.entry_frame}), req_item.entry_index};
                        mem_wdata = entry_from_word(req_item.entry_word);
                        fin       = 1'b1;
                    end
                    else if (!root_ok)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        mem_raddr  = {FW'({34'd0, root_frame}),
                                      req_item.virt_addr[47:39]};
                        level_next = 2'd0;
                        va_lo_next = req_item.virt_addr[38:12];
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                // The entry read in the previous cycle is on mem_rdata now.
                if (!mem_rdata.present)
                begin
                    fin = 1'b1;
                end
                else if (level_reg == 2'd3)
                begin
                    fin                    = 1'b1;
                    fin_item.mapped        = 1'b1;
                    fin_item.phys_frame    = mem_rdata.frame;
                    fin_item.writable      = mem_rdata.rw;
                    fin_item.user_access   = mem_rdata.user;
                    fin_item.cache_disable = mem_rdata.pcd;
                end
                else if (mem_rdata.frame >= FRAME_W'(FRAMES))
                begin
                    fin = 1'b1;
                end
                else
                begin
                    mem_raddr  = {mem_rdata.frame[FW-1:0], idx_next};
                    level_next = level_reg + 2'd1;
                end
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_item_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A finished item goes straight to the output register when it is free.
        if (fin)
        begin
            if (rsp_free)
            begin
                rsp_valid_next = 1'b1;
                rsp_item_next  = fin_item;
                state_next     = S_IDLE;
            end
            else
            begin
                res_next   = fin_item;
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            level_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            level_reg     <= level_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        va_lo_reg    <= va_lo_next;
        res_reg      <= res_next;
        rsp_item_reg <= rsp_item_next;
    end

    `FLPW_ASSERT_IMPL(a_clear_quiet, state_reg == S_CLEAR, !rsp_valid_reg && !req_accept, "transfer or pending result during clearing pass")
    `FLPW_ASSERT_IMPL(a_mapped_leaf, fin && fin_item.mapped, level_reg == 2'd3, "mapped result before the leaf level")
    `FLPW_ASSERT_IMPL(a_write_source, mem_we && state_reg != S_CLEAR, req_accept && req_item.action == ACT_WRITE, "table write without a write transfer")
    `FLPW_ASSERT_NEXT(a_busy_after_accept, req_accept, state_reg != S_IDLE || rsp_valid_reg, "accepted item left neither work nor result")

endmodule

`default_nettype wire

// ===== src/four_level_page_walk_top.sv =====
// Top level of the four-level page table walker.
`default_nettype none

// Four-level x86-64 style page walk over a private table store of FRAMES
// frames of 512 entries. After reset the store is swept to zero, one entry
// per cycle; req_stall stays high during the sweep while root_frame writes
// are still taken. A write request writes the table in the cycle it is
// accepted. A translate request that reaches the leaf makes four dependent
// reads, one per level, on the single read port of the table RAM, each with
// registered read data; a walk that stops at a missing entry or an
// out-of-range frame ends early. The result register lets the next request
// be taken while a result waits, but a finished item then holds until that
// result is transferred.
module four_level_page_walk_top #(
    parameter int FRAMES = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [5:0]          cfg_data,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire flpw_pkg::req_item_t req_item,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output flpw_pkg::rsp_item_t      rsp_item
);
    import flpw_pkg::*;

    localparam int DEPTH = FRAMES * ENTRIES_PER_TABLE;
    localparam int AW    = $clog2(FRAMES) + IDX_W;

    logic [5:0]    root_frame_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_frame_reg <= '0;
        end
        else if (cfg_we)
        begin
            root_frame_reg <= cfg_data;
        end
    end

    flpw_walker #(
        .FRAMES (FRAMES),
        .AW     (AW)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .root_frame (root_frame_reg),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_item   (req_item),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_item   (rsp_item),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    flpw_table_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the four-level page walk: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_top;
    import flpw_pkg::*;

    localparam int N_FRAMES     = 64;
    localparam int ITEMS_PER_PH = 140;
    localparam int HOLD_CYCLES  = 600;
    localparam int TAIL_CYCLES  = 20;
    // Covers the clearing sweep after reset and slow traffic.
    localparam int LIMIT_CYCLES = 400000;

    localparam rsp_item_t NO_MAP = '0;

    typedef struct {
        req_item_t item;
        bit        fixed;
        rsp_item_t rsp;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [5:0] cfg_data;
    logic      req_valid;
    logic      req_stall;
    req_item_t req_item;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp_item;

    // Software copy of the walker state.
    entry_t     pt_store [N_FRAMES*512];
    logic [5:0] cur_root;
    rsp_item_t  expected_walks [$];

    dir_row_t    directed_rows [$];
    logic [47:0] last_va = '0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          phase_items = 0;
    int          errors = 0;
    int          n_writes = 0;
    int          n_walks = 0;
    int          n_leaf = 0;
    bit          hold_go = 1'b0;
    logic        rsp_hold = 1'b0;

    four_level_page_walk_top #(.FRAMES(N_FRAMES)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rsp_item_t walk_predict(input req_item_t it);
        rsp_item_t   r;
        entry_t      e;
        logic [39:0] fr;
        logic [8:0]  idx;
        r = '0;
        e = '0;
        if (it.action == ACT_WRITE)
        begin
            if (int'(it.entry_frame) < N_FRAMES)
            begin
                e.frame   = it.entry_word[51:12];
                e.pcd     = it.entry_word[4];
                e.user    = it.entry_word[2];
                e.rw      = it.entry_word[1];
                e.present = it.entry_word[0];
                pt_store[{it.entry_frame, it.entry_index}] = e;
            end
            return r;
        end
        fr = 40'(cur_root);
        for (int lvl = 0; lvl < 4; lvl++)
        begin
            if (fr >= 40'(N_FRAMES))
                return r;
            idx = it.virt_addr[39 - 9*lvl +: 9];
            e = pt_store[{fr[5:0], idx}];
            if (!e.present)
                return r;
            fr = e.frame;
        end
        r.mapped        = 1'b1;
        r.phys_frame    = fr;
        r.writable      = e.rw;
        r.user_access   = e.user;
        r.cache_disable = e.pcd;
        return r;
    endfunction

    function automatic rsp_item_t leaf_hit(input logic [39:0] f, input logic rw,
                                           input logic us, input logic pcd);
        rsp_item_t r;
        r.mapped        = 1'b1;
        r.phys_frame    = f;
        r.writable      = rw;
        r.user_access   = us;
        r.cache_disable = pcd;
        return r;
    endfunction

    // A write always answers with the all-zero result.
    function automatic dir_row_t row_write(input logic [5:0] f, input logic [8:0] i,
                                           input logic [63:0] w);
        dir_row_t d;
        d.item             = '0;
        d.item.action      = ACT_WRITE;
        d.item.entry_frame = f;
        d.item.entry_index = i;
        d.item.entry_word  = w;
        d.fixed            = 1'b1;
        d.rsp              = NO_MAP;
        return d;
    endfunction

    function automatic dir_row_t row_walk(input logic [47:0] va, input bit fixed,
                                          input rsp_item_t rsp);
        dir_row_t d;
        d.item           = '0;
        d.item.action    = ACT_TRANSLATE;
        d.item.virt_addr = va;
        d.fixed          = fixed;
        d.rsp            = rsp;
        return d;
    endfunction

    function automatic req_item_t rand_req();
        return req_item_t'({$urandom, $urandom, $urandom, $urandom});
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offer one item and wait for its transfer; the expectation is queued at acceptance.
    task automatic send_req(input req_item_t it, input bit fixed, input rsp_item_t fixed_rsp);
        rsp_item_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        want = walk_predict(it);
        if (fixed)
            want = fixed_rsp;
        expected_walks.push_back(want);
        if (it.action == ACT_WRITE)
            n_writes++;
        else
            n_walks++;
        phase_items++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (expected_walks.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_root(input logic [5:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_root = v;
    endtask

    // Build a four-level path for a random address, then look up it, its neighbors or random addresses.
    task automatic map_burst();
        logic [47:0] va;
        logic [39:0] fr;
        logic [39:0] nf;
        logic [11:0] flags;
        logic [63:0] r64;
        req_item_t   it;
        int          n;
        r64 = rand64();
        va  = r64[47:0];
        if ($urandom_range(2) == 0)
            va[47:21] = last_va[47:21];
        fr = 40'(cur_root);
        for (int lvl = 0; lvl < 4; lvl++)
        begin
            r64 = rand64();
            if (lvl == 3 || $urandom_range(15) == 0)
                nf = r64[39:0];
            else
                nf = 40'($urandom_range(N_FRAMES-1));
            flags    = 12'($urandom);
            flags[0] = ($urandom_range(15) != 0);
            it                = rand_req();
            it.action         = ACT_WRITE;
            it.entry_frame    = fr[5:0];
            it.entry_index    = va[39 - 9*lvl +: 9];
            it.entry_word     = {it.entry_word[63:52], nf, flags};
            send_req(it, 1'b0, NO_MAP);
            fr = nf;
        end
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            it        = rand_req();
            it.action = ACT_TRANSLATE;
            case ($urandom_range(3))
                0: it.virt_addr = va;
                1: it.virt_addr = {va[47:12], it.virt_addr[11:0]};
                2: it.virt_addr = {va[47:21], it.virt_addr[20:0]};
                default: ;
            endcase
            send_req(it, 1'b0, NO_MAP);
        end
        last_va = va;
    endtask

    task automatic check_rsp(input rsp_item_t got);
        rsp_item_t want;
        if (expected_walks.size() == 0)
        begin
            $display("%0t: result %h arrived with nothing outstanding", $time, got);
            errors++;
            return;
        end
        want = expected_walks.pop_front();
        if (want.mapped)
            n_leaf++;
        if (got.mapped !== want.mapped)
        begin
            $display("%0t: mapped expected %0b actual %0b", $time, want.mapped, got.mapped);
            errors++;
        end
        if (got.phys_frame !== want.phys_frame)
        begin
            $display("%0t: phys_frame expected %h actual %h",
                     $time, want.phys_frame, got.phys_frame);
            errors++;
        end
        if (got.writable !== want.writable)
        begin
            $display("%0t: writable expected %0b actual %0b",
                     $time, want.writable, got.writable);
            errors++;
        end
        if (got.user_access !== want.user_access)
        begin
            $display("%0t: user_access expected %0b actual %0b",
                     $time, want.user_access, got.user_access);
            errors++;
        end
        if (got.cache_disable !== want.cache_disable)
        begin
            $display("%0t: cache_disable expected %0b actual %0b",
                     $time, want.cache_disable, got.cache_disable);
            errors++;
        end
    endtask

    // Result side: check each transfer, then pick the stall for the next cycle.
    initial
    begin
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                check_rsp(rsp_item);
            rsp_stall <= rsp_hold || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Long output hold-off, so the walker backs up and stalls its input.
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        rsp_hold <= 1'b0;
    end

    initial
    begin
        int unsigned cyc;
        cyc = 0;
        while (cyc < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cyc++;
        end
        $display("%0t: run did not finish in %0d cycles", $time, LIMIT_CYCLES);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [5:0] roots [4];
        int         idle_mix [4];
        int         stall_mix [4];
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_item  <= '0;
        cfg_we    <= 1'b0;
        cfg_data  <= '0;
        foreach (pt_store[i])
            pt_store[i] = '0;
        cur_root  = '0;
        roots     = '{6'd63, 6'($urandom_range(1, 62)), 6'd0, 6'($urandom)};
        idle_mix  = '{0, 64, 0, 37};
        stall_mix = '{0, 0, 64, 37};

        // Root is 0 and the store is empty when the directed table starts.
        directed_rows = {
            row_walk(48'h0, 1'b1, NO_MAP),
            row_walk(48'hFFFF_FFFF_FFFF, 1'b1, NO_MAP),
            row_write(6'd0, 9'd0, 64'hFFFF_FFFF_FFFF_FFFF),
            row_walk(48'h0, 1'b1, NO_MAP),
            row_write(6'd0, 9'd0, {12'h0, 40'd1, 12'h001}),
            row_write(6'd1, 9'd0, {12'h0, 40'd2, 12'h001}),
            row_write(6'd2, 9'd0, {12'h0, 40'd3, 12'h001}),
            row_walk(48'h0, 1'b1, NO_MAP),
            row_write(6'd3, 9'd0, 64'hFFFF_FFFF_FFFF_FFFF),
            row_walk(48'h0, 1'b1, leaf_hit(40'hFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1)),
            row_write(6'd3, 9'd0, 64'hFFF0_0000_0000_0FE9),
            row_walk(48'h0, 1'b1, leaf_hit(40'h0, 1'b0, 1'b0, 1'b0)),
            row_walk(48'h0000_0000_0FFF, 1'b1, leaf_hit(40'h0, 1'b0, 1'b0, 1'b0)),
            row_walk(48'h0000_0000_1000, 1'b1, NO_MAP),
            row_write(6'd0, 9'd511, {12'h0, 40'd63, 12'h001}),
            row_write(6'd63, 9'd511, {12'h0, 40'd62, 12'h003}),
            row_write(6'd62, 9'd511, {12'h0, 40'd61, 12'h005}),
            row_write(6'd61, 9'd511, {12'h0, 40'h80_0000_0001, 12'h013}),
            row_walk(48'hFFFF_FFFF_FFFF, 1'b1, leaf_hit(40'h80_0000_0001, 1'b1, 1'b0, 1'b1)),
            row_walk(48'hFFFF_FFFF_F000, 1'b0, NO_MAP),
            row_write(6'd61, 9'd511, {12'hABC, 40'h12_3456_789A, 12'h016}),
            row_walk(48'hFFFF_FFFF_FFFF, 1'b1, NO_MAP),
            row_write(6'd0, 9'd256, 64'hA5A5_A5A5_A5A5_A5A5),
            row_walk(48'h8000_0000_0000, 1'b0, NO_MAP)
        };

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_root(6'd0);

        foreach (directed_rows[i])
            send_req(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].rsp);

        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            set_root(roots[ph]);
            send_idle_pct  = idle_mix[ph];
            recv_stall_pct = stall_mix[ph];
            phase_items    = 0;
            while (phase_items < ITEMS_PER_PH)
            begin
                if (ph == 0 && phase_items >= 40)
                    hold_go = 1'b1;
                if ($urandom_range(4) != 0)
                    map_burst();
                else
                    send_req(rand_req(), 1'b0, NO_MAP);
            end
        end

        drain();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("Covered %0d table writes and %0d translations, %0d of them reaching a leaf,",
                 n_writes, n_walks, n_leaf);
        $display("under four root frames and four idle/stall mixes with one long output hold.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/flpw_pkg.sv
src/flpw_table_ram.sv
src/flpw_walker.sv
src/four_level_page_walk_top.sv
tb/tb_top.sv
